FILE: hdl/csvs_pkg.sv
// Shared types and constants for the CSV stream field splitter.
// Depends on nothing; every other file of the block imports it.
package csvs_pkg;

   // Widest header the splitter keeps; later fields are dropped.
   localparam int MAX_COLUMNS  = 256;
   localparam int COUNT_W      = $clog2(MAX_COLUMNS + 1);

   localparam int COLUMN_W     = 8;
   localparam int ROW_W        = 32;
   localparam int PAD_W        = 8;
   localparam int BYTE_W       = 8;

   // Depth of the command queue between the front and back ends.
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;

   typedef enum logic [0:0] {
      OP_BYTE = 1'b0,
      OP_END  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_ROW_END   = 2'd2,
      KIND_INPUT_END = 2'd3
   } kind_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [BYTE_W-1:0]   data_byte;
   } req_type;

   typedef struct packed {
      kind_type            kind;
      logic [BYTE_W-1:0]   value;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row_number;
      logic [PAD_W-1:0]    pad_count;
      logic                last;
   } rsp_type;

   // One classified input word: which events it raises and their payload.
   typedef struct packed {
      logic                has_byte;
      logic                has_field_end;
      logic                has_row_end;
      logic                has_input_end;
      logic [BYTE_W-1:0]   value;
      logic [COLUMN_W-1:0] column;
      logic [ROW_W-1:0]    row;
      logic [ROW_W-1:0]    end_row;
      logic [PAD_W-1:0]    pad;
   } cmd_type;

endpackage

FILE: hdl/csvs_front.sv
// Front end: accepts input words, tracks quoting and row state, and
// turns each word into at most one command for the queue. Depends on csvs_pkg.
module csvs_front
   import csvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push_valid,
   output cmd_type push_data
);

   logic               inside_quotes_ff, inside_quotes_in;
   logic               quote_pending_ff, quote_pending_in;
   logic               cr_pending_ff,    cr_pending_in;
   logic               field_started_ff, field_started_in;
   logic [COUNT_W-1:0] field_count_ff,   field_count_in;
   logic [COUNT_W-1:0] row_width_ff,     row_width_in;
   logic [ROW_W-1:0]   row_counter_ff,   row_counter_in;

   logic               accept;
   logic [COUNT_W-1:0] limit;
   logic [COUNT_W-1:0] count_after;
   logic [COUNT_W-1:0] pad_diff;
   logic [31:0]        pad_wide;
   logic               plain;
   logic               byte_req;
   logic               field_req;
   logic               row_req;
   logic               end_req;
   logic [BYTE_W-1:0]  c;
   cmd_type            cmd;

   assign accept    = req_valid && !queue_full;
   assign req_ready = !queue_full;
   assign c         = req_data.data_byte;
   assign limit     = (row_width_ff != '0) ? row_width_ff : COUNT_W'(MAX_COLUMNS);

   always_comb begin
      inside_quotes_in = inside_quotes_ff;
      quote_pending_in = quote_pending_ff;
      cr_pending_in    = cr_pending_ff;
      field_started_in = field_started_ff;
      field_count_in   = field_count_ff;
      row_width_in     = row_width_ff;
      row_counter_in   = row_counter_ff;
      plain            = 1'b0;
      byte_req         = 1'b0;
      field_req        = 1'b0;
      row_req          = 1'b0;
      end_req          = 1'b0;
      count_after      = field_count_ff;
      pad_diff         = '0;
      pad_wide         = '0;
      cmd              = '0;

      // Classify the word.
      if (req_data.opcode == OP_BYTE) begin
         if (quote_pending_ff) begin
            quote_pending_in = 1'b0;
            if (c == CHAR_QUOTE) begin
               byte_req = 1'b1;
            end else begin
               inside_quotes_in = 1'b0;
               plain            = 1'b1;
            end
         end else if (inside_quotes_ff) begin
            if (c == CHAR_QUOTE) begin
               quote_pending_in = 1'b1;
            end else begin
               byte_req = 1'b1;
            end
         end else begin
            plain = 1'b1;
         end

         if (plain) begin
            cr_pending_in = 1'b0;
            if (!(cr_pending_ff && c == CHAR_LF)) begin
               if (c == CHAR_QUOTE && !field_started_ff) begin
                  inside_quotes_in = 1'b1;
                  field_started_in = 1'b1;
               end else if (c == CHAR_COMMA) begin
                  field_req = 1'b1;
               end else if (c == CHAR_CR) begin
                  row_req       = 1'b1;
                  cr_pending_in = 1'b1;
               end else if (c == CHAR_LF) begin
                  row_req = 1'b1;
               end else begin
                  byte_req         = 1'b1;
                  field_started_in = 1'b1;
               end
            end
         end
      end else begin
         end_req = 1'b1;
         row_req = field_started_ff || (field_count_ff != '0);
      end

      cmd.value  = c;
      cmd.column = COLUMN_W'(field_count_ff);
      cmd.row    = row_counter_ff;

      if (byte_req) begin
         cmd.has_byte = (field_count_ff < limit);
      end

      if (field_req || row_req) begin
         if (field_count_ff < limit) begin
            cmd.has_field_end = 1'b1;
            count_after       = field_count_ff + COUNT_W'(1);
         end
         field_count_in   = count_after;
         field_started_in = 1'b0;
      end

      if (row_req) begin
         cmd.has_row_end = 1'b1;
         if (row_width_ff == '0) begin
            row_width_in = count_after;
         end else if (count_after < row_width_ff) begin
            pad_diff = row_width_ff - count_after;
            pad_wide = 32'(pad_diff);
            cmd.pad  = (pad_wide > 32'd255) ? '1 : PAD_W'(pad_wide);
         end
         if (row_counter_ff != '1) begin
            row_counter_in = row_counter_ff + ROW_W'(1);
         end
         field_count_in = '0;
      end

      cmd.end_row = row_counter_in;

      // End of input returns the parser to its reset state.
      if (end_req) begin
         cmd.has_input_end = 1'b1;
         inside_quotes_in  = 1'b0;
         quote_pending_in  = 1'b0;
         cr_pending_in     = 1'b0;
         field_started_in  = 1'b0;
         field_count_in    = '0;
         row_width_in      = '0;
         row_counter_in    = '0;
      end
   end

   assign push_data  = cmd;
   assign push_valid = accept && (cmd.has_byte || cmd.has_field_end ||
                                  cmd.has_row_end || cmd.has_input_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_quotes_ff <= 1'b0;
         quote_pending_ff <= 1'b0;
         cr_pending_ff    <= 1'b0;
         field_started_ff <= 1'b0;
         field_count_ff   <= '0;
         row_width_ff     <= '0;
         row_counter_ff   <= '0;
      end else if (accept) begin
         inside_quotes_ff <= inside_quotes_in;
         quote_pending_ff <= quote_pending_in;
         cr_pending_ff    <= cr_pending_in;
         field_started_ff <= field_started_in;
         field_count_ff   <= field_count_in;
         row_width_ff     <= row_width_in;
         row_counter_ff   <= row_counter_in;
      end
   end

endmodule

FILE: hdl/csvs_queue.sv
// Short command queue between the front and back ends.
// Depends on csvs_pkg for the command type and the depth.
module csvs_queue
   import csvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_data,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_data,
   input  logic    pop
);

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/csvs_back.sv
// Back end: expands the command at the queue head into result words,
// one per cycle while the receiver is ready, into the output register. Depends on csvs_pkg.
module csvs_back
   import csvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  cmd_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Events of the head command already sent, in order byte, field end,
   // row end, input end.
   logic [3:0] done_ff,      done_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff,       rsp_in;
   logic [3:0] remaining;
   logic [3:0] pick;
   logic       load;
   logic       final_event;

   assign load      = !rsp_valid_ff || rsp_ready;
   assign remaining = {head_data.has_input_end, head_data.has_row_end,
                       head_data.has_field_end, head_data.has_byte} & ~done_ff;
   assign pick        = remaining & (~remaining + 4'd1);
   assign final_event = ((remaining & ~pick) == 4'd0);

   always_comb begin
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            rsp_in = '0;
            if (pick[0]) begin
               rsp_in.kind   = KIND_BYTE;
               rsp_in.value  = head_data.value;
               rsp_in.column = head_data.column;
               rsp_in.row_number = head_data.row;
            end else if (pick[1]) begin
               rsp_in.kind   = KIND_FIELD_END;
               rsp_in.column = head_data.column;
               rsp_in.row_number = head_data.row;
            end else if (pick[2]) begin
               rsp_in.kind      = KIND_ROW_END;
               rsp_in.row_number = head_data.row;
               rsp_in.pad_count = head_data.pad;
            end else begin
               rsp_in.kind      = KIND_INPUT_END;
               rsp_in.row_number = head_data.end_row;
            end
            rsp_in.last = final_event;
            if (final_event) begin
               pop     = 1'b1;
               done_in = '0;
            end else begin
               done_in = done_ff | pick;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/csv_stream_field_splitter.sv
// Top level of the CSV stream field splitter.
// Depends on csvs_pkg, csvs_front, csvs_queue and csvs_back.
//
// The request channel takes one word per cycle while ready: either one
// text byte or an end-of-input marker. The response channel returns the
// events each word causes: field bytes, end of field, end of row (with the
// number of pad fields a short row needs) and end of input (with the row
// total). A word causes zero to three events; its last event is marked.
//
// The front end accepts a word in every cycle in which the command queue
// has room, updates the quote, CR and row state at once and pushes at most
// one command. The back end turns the head command into events through
// an output register. A word's command passes the queue and that register
// before its first event is presented. Throughput is one event per cycle
// while the receiver is ready, so words with one event or none flow at one
// per cycle; a word with two or three events holds the back end until all
// are out; the four-command queue absorbs bursts before requests stall.
//
// When the receiver stalls, the output register holds its word, the queue
// fills and the request ready drops only once the queue is full. Reset
// empties the queue and output register and returns the parser to the
// start of a document: no header seen, row zero, outside quotes.
module csv_stream_field_splitter
   import csvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push_valid;
   cmd_type push_data;
   logic    queue_full;
   logic    head_valid;
   cmd_type head_data;
   logic    pop;

   // Classification and parser state.
   csvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Decouples the front end from stalls on the response side.
   csvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   // Event expansion and the output register.
   csvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
